### hdl/ecps_pkg.sv
// shared types and constants for the earliest completion path selector
// no dependencies
package ecps_pkg;

    localparam int PATHS_DEF = 8;

    localparam int IDX_W    = 3;
    localparam int BYTE_W   = 48;
    localparam int WIN_W    = 32;
    localparam int RTT_W    = 24;
    localparam int BW_W     = 40;
    localparam int PKT_W    = 32;
    localparam int LEN_W    = 16;
    localparam int TIME_W   = 60;
    localparam int IN_DW    = 280;
    localparam int OUT_DW   = 64;

    // divider operand widths: dividend up to t*100, divisor up to a derived bandwidth
    localparam int DVD_W    = 64;
    localparam int DSR_W    = 52;
    localparam int DCNT_W   = 7;

    localparam logic [RTT_W-1:0]  RTT_DEFAULT  = 24'd100000;
    localparam logic [DSR_W-1:0]  BW_DEFAULT   = 52'd125000;
    localparam logic [19:0]       USEC_PER_SEC = 20'd1000000;
    localparam logic [PKT_W-1:0]  LOSS_MIN_PKT = 32'd100;
    localparam logic [6:0]        PCT_SCALE    = 7'd100;
    localparam logic [6:0]        LOSS_LIMIT   = 7'd50;
    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_INIT,
        CMD_LOAD,
        CMD_NEXT,
        CMD_BW_DEF,
        CMD_BW_DIV,
        CMD_BW_TAKE,
        CMD_TIME_DIV,
        CMD_TIME_SUM,
        CMD_LOSS_DIV,
        CMD_PCT,
        CMD_SCALE_DIV,
        CMD_SCALE_TAKE,
        CMD_COMPARE,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        logic active;
        logic last_path;
        logic bw_zero;
        logic win_zero;
        logic loss_check;
        logic pct_ok;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

### hdl/ecps_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on ecps_pkg
module ecps_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ecps_pkg::DVD_W-1:0]  dividend,
    input  logic [ecps_pkg::DSR_W-1:0]  divisor,
    output logic [ecps_pkg::DVD_W-1:0]  quotient,
    output logic                        busy,
    output logic                        done
);
    import ecps_pkg::*;

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DSR_W:0]    wide;
    logic              ge;

    always_comb
    begin
        wide      = {rem_reg, quo_reg[DVD_W-1]};
        ge        = (wide >= {1'b0, dsr_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DCNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DSR_W'(wide - {1'b0, dsr_reg}) : wide[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

### hdl/ecps_datapath.sv
// path statistics table, estimate arithmetic, best tracking and output register
// depends on ecps_pkg and ecps_div
module ecps_datapath #(
    parameter int PATHS = ecps_pkg::PATHS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ecps_pkg::cmd_t               cmd,
    output ecps_pkg::status_t            status,
    input  logic                         cfg_we,
    input  logic [ecps_pkg::IDX_W-1:0]   cfg_wdata,
    input  logic [ecps_pkg::IN_DW-1:0]   in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ecps_pkg::OUT_DW-1:0]  out_data,
    output logic                         out_found
);
    import ecps_pkg::*;

    localparam int PIW = (PATHS > 1) ? $clog2(PATHS) : 1;

    // input fields
    logic [IDX_W-1:0]  f_idx;
    logic              f_act;
    logic [BYTE_W-1:0] f_tx, f_ack;
    logic [WIN_W-1:0]  f_win;
    logic [RTT_W-1:0]  f_rtt;
    logic [BW_W-1:0]   f_bw;
    logic [PKT_W-1:0]  f_sent, f_lost;
    logic [LEN_W-1:0]  f_len;

    assign f_idx  = in_data[2:0];
    assign f_act  = in_data[3];
    assign f_tx   = in_data[51:4];
    assign f_ack  = in_data[99:52];
    assign f_win  = in_data[131:100];
    assign f_rtt  = in_data[155:132];
    assign f_bw   = in_data[195:156];
    assign f_sent = in_data[227:196];
    assign f_lost = in_data[259:228];
    assign f_len  = in_data[275:260];

    // statistics table
    logic              act_reg  [PATHS];
    logic [BYTE_W-1:0] tx_reg   [PATHS];
    logic [BYTE_W-1:0] ack_reg  [PATHS];
    logic [WIN_W-1:0]  win_reg  [PATHS];
    logic [RTT_W-1:0]  rtt_reg  [PATHS];
    logic [BW_W-1:0]   bw_reg   [PATHS];
    logic [PKT_W-1:0]  sent_reg [PATHS];
    logic [PKT_W-1:0]  lost_reg [PATHS];

    logic [IDX_W-1:0]  fallback_reg;
    logic [PIW-1:0]    p_reg, best_p_reg;
    logic              found_reg;
    logic [TIME_W-1:0] best_t_reg, t_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WIN_W-1:0]  e_win_reg;
    logic [RTT_W-1:0]  e_rtt_reg;
    logic [DSR_W-1:0]  e_bw_reg;
    logic [PKT_W-1:0]  e_sent_reg, e_lost_reg;
    logic [WIN_W:0]    sum_reg;
    logic              pct_ok_reg;
    logic [5:0]        pct_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_path_reg;
    logic              out_found_reg;
    logic [TIME_W-1:0] out_time_reg;

    logic              wr_hit;
    logic [BYTE_W-1:0] diff;
    logic [WIN_W-1:0]  inflight;
    logic [RTT_W-1:0]  rtt_eff;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd, quo;
    logic [DSR_W-1:0]  div_dsr;
    logic              div_busy, div_done;
    logic              better;
    logic [4:0]        best_p_wide;
    logic [TIME_W-1:0] scaled;

    assign wr_hit = (cmd == CMD_WRITE) && (5'(f_idx) < 5'(PATHS));

    always_comb
    begin
        diff     = (tx_reg[p_reg] > ack_reg[p_reg]) ? tx_reg[p_reg] - ack_reg[p_reg] : '0;
        inflight = (diff > BYTE_W'(win_reg[p_reg])) ? win_reg[p_reg] : diff[WIN_W-1:0];
        rtt_eff  = (rtt_reg[p_reg] == '0) ? RTT_DEFAULT : rtt_reg[p_reg];
    end

    // operand selection for the shared divider
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
        case (cmd)
            CMD_BW_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(e_win_reg) * DVD_W'(USEC_PER_SEC);
                div_dsr   = DSR_W'(e_rtt_reg);
            end
            CMD_TIME_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(sum_reg) * DVD_W'(USEC_PER_SEC);
                div_dsr   = e_bw_reg;
            end
            CMD_LOSS_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(e_lost_reg) * DVD_W'(PCT_SCALE);
                div_dsr   = DSR_W'(e_sent_reg);
            end
            CMD_SCALE_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(t_reg) * DVD_W'(PCT_SCALE);
                div_dsr   = DSR_W'(PCT_SCALE - 7'(pct_reg));
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ecps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign better      = !found_reg || (t_reg < best_t_reg);
    assign best_p_wide = 5'(best_p_reg);
    assign scaled      = (quo > DVD_W'(TIME_MAX)) ? TIME_MAX : quo[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATHS; i++)
            begin
                act_reg[i]  <= 1'b0;
                tx_reg[i]   <= '0;
                ack_reg[i]  <= '0;
                win_reg[i]  <= '0;
                rtt_reg[i]  <= '0;
                bw_reg[i]   <= '0;
                sent_reg[i] <= '0;
                lost_reg[i] <= '0;
            end
            fallback_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            p_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
                fallback_reg <= cfg_wdata;
            if (wr_hit)
            begin
                act_reg[PIW'(f_idx)]  <= f_act;
                tx_reg[PIW'(f_idx)]   <= f_tx;
                ack_reg[PIW'(f_idx)]  <= f_ack;
                win_reg[PIW'(f_idx)]  <= f_win;
                rtt_reg[PIW'(f_idx)]  <= f_rtt;
                bw_reg[PIW'(f_idx)]   <= f_bw;
                sent_reg[PIW'(f_idx)] <= f_sent;
                lost_reg[PIW'(f_idx)] <= f_lost;
            end
            if (cmd == CMD_INIT)
            begin
                p_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (cmd == CMD_NEXT)
                p_reg <= p_reg + 1'b1;
            if (cmd == CMD_COMPARE)
            begin
                p_reg <= p_reg + 1'b1;
                if (better)
                    found_reg <= 1'b1;
            end
            if (cmd == CMD_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_INIT:
            begin
                len_reg <= f_len;
            end
            CMD_LOAD:
            begin
                e_win_reg  <= win_reg[p_reg];
                e_rtt_reg  <= rtt_eff;
                e_bw_reg   <= DSR_W'(bw_reg[p_reg]);
                e_sent_reg <= sent_reg[p_reg];
                e_lost_reg <= lost_reg[p_reg];
                sum_reg    <= (WIN_W+1)'(inflight) + (WIN_W+1)'(len_reg);
            end
            CMD_BW_DEF:
            begin
                e_bw_reg <= BW_DEFAULT;
            end
            CMD_BW_TAKE:
            begin
                e_bw_reg <= (quo == '0) ? DSR_W'(1) : quo[DSR_W-1:0];
            end
            CMD_TIME_SUM:
            begin
                t_reg <= TIME_W'(quo) + TIME_W'(e_rtt_reg);
            end
            CMD_PCT:
            begin
                pct_ok_reg <= (quo != '0) && (quo < DVD_W'(LOSS_LIMIT));
                pct_reg    <= quo[5:0];
            end
            CMD_SCALE_TAKE:
            begin
                t_reg <= scaled;
            end
            CMD_COMPARE:
            begin
                if (better)
                begin
                    best_t_reg <= t_reg;
                    best_p_reg <= p_reg;
                end
            end
            CMD_RESULT:
            begin
                out_path_reg  <= found_reg ? best_p_wide[IDX_W-1:0] : fallback_reg;
                out_found_reg <= found_reg;
                out_time_reg  <= found_reg ? best_t_reg : '0;
            end
            default:
            begin
                pct_reg <= pct_reg;
            end
        endcase
    end

    always_comb
    begin
        status.active     = act_reg[p_reg];
        status.last_path  = (p_reg == PIW'(PATHS - 1));
        status.bw_zero    = (e_bw_reg == '0);
        status.win_zero   = (e_win_reg == '0);
        status.loss_check = (e_sent_reg > LOSS_MIN_PKT);
        status.pct_ok     = pct_ok_reg;
        status.div_done   = div_done;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_data  = {1'b0, out_time_reg, out_path_reg};

`ifndef NO_ASSERTIONS
    a_fallback_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_time_reg == '0)
        else $error("fallback result carries a nonzero time");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_RESULT |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while pending");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

### hdl/ecps_ctrl.sv
// sequencer that walks the paths and steps the datapath through each estimate
// depends on ecps_pkg
module ecps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_select,
    output logic               in_ready,
    input  ecps_pkg::status_t  status,
    output ecps_pkg::cmd_t     cmd
);
    import ecps_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE       = 12'b000000000001,
        S_CHECK      = 12'b000000000010,
        S_BW         = 12'b000000000100,
        S_BW_WAIT    = 12'b000000001000,
        S_TIME       = 12'b000000010000,
        S_TIME_WAIT  = 12'b000000100000,
        S_LOSS       = 12'b000001000000,
        S_LOSS_WAIT  = 12'b000010000000,
        S_SCALE      = 12'b000100000000,
        S_SCALE_WAIT = 12'b001000000000,
        S_COMPARE    = 12'b010000000000,
        S_RESULT     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_select)
                    begin
                        cmd        = CMD_INIT;
                        state_next = S_CHECK;
                    end
                    else
                        cmd = CMD_WRITE;
                end
            end
            S_CHECK:
            begin
                if (status.active)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_BW;
                end
                else if (status.last_path)
                    state_next = S_RESULT;
                else
                    cmd = CMD_NEXT;
            end
            S_BW:
            begin
                if (!status.bw_zero)
                    state_next = S_TIME;
                else if (status.win_zero)
                begin
                    cmd        = CMD_BW_DEF;
                    state_next = S_TIME;
                end
                else
                begin
                    cmd        = CMD_BW_DIV;
                    state_next = S_BW_WAIT;
                end
            end
            S_BW_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_BW_TAKE;
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                cmd        = CMD_TIME_DIV;
                state_next = S_TIME_WAIT;
            end
            S_TIME_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_TIME_SUM;
                    state_next = S_LOSS;
                end
            end
            S_LOSS:
            begin
                if (status.loss_check)
                begin
                    cmd        = CMD_LOSS_DIV;
                    state_next = S_LOSS_WAIT;
                end
                else
                    state_next = S_COMPARE;
            end
            S_LOSS_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_PCT;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (status.pct_ok)
                begin
                    cmd        = CMD_SCALE_DIV;
                    state_next = S_SCALE_WAIT;
                end
                else
                    state_next = S_COMPARE;
            end
            S_SCALE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_SCALE_TAKE;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd        = CMD_COMPARE;
                state_next = status.last_path ? S_RESULT : S_CHECK;
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/earliest_completion_path_select.sv
// top level of the earliest completion path selector
// depends on ecps_pkg, ecps_ctrl and ecps_datapath
//
// Keeps a statistics table of PATHS entries and, for each select item, returns
// the active path whose estimated delivery time (rtt plus queued and new bytes
// over bandwidth, scaled up for loss) is smallest, the lower index winning a
// tie, or the fallback path when no path is active. A write item (tuser 0) gives
// no result. A select item (tuser 1) walks the paths one after another on a
// single shared 64-bit divider that makes one quotient bit per cycle: an active
// path costs one to four divisions, an inactive one none. One item is worked on
// at a time; the result sits in an output register, so writes are still taken
// while a result waits.
module earliest_completion_path_select #(
    parameter int PATHS = ecps_pkg::PATHS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: fallback path
    input  logic                         cfg_we,
    input  logic [ecps_pkg::IDX_W-1:0]   cfg_wdata,
    // input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // path_index, path_active, sent_bytes, acked_total, cwnd, rtt_us, bandwidth,
    // sent_pkts, lost_pkts, packet_length, zero pad
    input  logic [ecps_pkg::IN_DW-1:0]   s_axis_tdata,
    input  logic                         s_axis_tuser,   // command
    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ecps_pkg::OUT_DW-1:0]  m_axis_tdata,   // chosen_path, eta_us, pad
    output logic                         m_axis_tuser    // found_active
);
    import ecps_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing of the per-path estimate steps
    ecps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_select (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // table, arithmetic and result register
    ecps_datapath #(
        .PATHS (PATHS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_found (m_axis_tuser)
    );

endmodule

### test/tb_earliest_completion_path_select.sv
// testbench for earliest_completion_path_select: directed and random path table
// writes and selects, checked against an in-bench completion time predictor
// depends on ecps_pkg and the earliest_completion_path_select rtl
module tb_earliest_completion_path_select;
    import ecps_pkg::*;

    localparam int NPATH      = 8;
    localparam int RAND_ITEMS = 1650;
    localparam int IDLE_LIMIT = 40000;   // cycles with no item moved on either side
    localparam int LONG_HOLD  = 6000;    // receiver hold-off, longer than two slow selects
    localparam int SETTLE     = 12;      // time for a trailing write to finish

    localparam logic CMD_WR  = 1'b0;
    localparam logic CMD_SEL = 1'b1;

    // input item fields, lowest bits last so path_index lands at bit 0
    typedef struct packed {
        logic [3:0]        pad;
        logic [LEN_W-1:0]  len;
        logic [PKT_W-1:0]  lost;
        logic [PKT_W-1:0]  sent_pkts;
        logic [BW_W-1:0]   bw;
        logic [RTT_W-1:0]  rtt;
        logic [WIN_W-1:0]  cwnd;
        logic [BYTE_W-1:0] acked;
        logic [BYTE_W-1:0] sent;
        logic              active;
        logic [IDX_W-1:0]  idx;
    } path_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  path;
        logic              found;
        logic [TIME_W-1:0] eta;
    } choice_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;    // path item fields, see path_item_t
    logic                s_axis_tuser;    // command
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_DW-1:0]   m_axis_tdata;    // chosen_path, eta_us, pad
    logic                m_axis_tuser;    // found_active

    earliest_completion_path_select u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of the path table and the fallback register
    logic              tbl_active [NPATH];
    logic [BYTE_W-1:0] tbl_sent   [NPATH];
    logic [BYTE_W-1:0] tbl_acked  [NPATH];
    logic [WIN_W-1:0]  tbl_cwnd   [NPATH];
    logic [RTT_W-1:0]  tbl_rtt    [NPATH];
    logic [BW_W-1:0]   tbl_bw     [NPATH];
    logic [PKT_W-1:0]  tbl_spkts  [NPATH];
    logic [PKT_W-1:0]  tbl_lost   [NPATH];
    logic [IDX_W-1:0]  fallback;

    choice_t pending_choices[$];

    int  errors;
    int  n_writes;
    int  n_selects;
    int  n_fallbacks;
    int  n_checked;
    bit  gaps_on;       // random idling on both sides
    bit  long_hold_req; // asks the receiver for one long hold-off
    int  idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // delivery time estimate of one path, all in 64-bit unsigned arithmetic
    function automatic logic [63:0] path_eta(int p, logic [LEN_W-1:0] len);
        logic [63:0] inflight;
        logic [63:0] rtt;
        logic [63:0] bw;
        logic [63:0] t;
        logic [63:0] pct;
        inflight = (tbl_sent[p] > tbl_acked[p]) ? 64'(tbl_sent[p] - tbl_acked[p]) : 64'd0;
        if (inflight > 64'(tbl_cwnd[p]))
        begin
            inflight = 64'(tbl_cwnd[p]);
        end
        rtt = (tbl_rtt[p] == '0) ? 64'd100000 : 64'(tbl_rtt[p]);
        bw  = 64'(tbl_bw[p]);
        if (bw == 0)
        begin
            // unknown bandwidth: derive from the window, default without one
            bw = (tbl_cwnd[p] != '0) ? (64'(tbl_cwnd[p]) * 64'd1000000) / rtt : 64'd125000;
            if (bw == 0)
            begin
                bw = 64'd1;
            end
        end
        t = rtt + ((inflight + 64'(len)) * 64'd1000000) / bw;
        if (tbl_spkts[p] > 32'd100)
        begin
            pct = (64'(tbl_lost[p]) * 64'd100) / 64'(tbl_spkts[p]);
            if (pct > 0 && pct < 64'd50)
            begin
                t = (t * 64'd100) / (64'd100 - pct);
            end
        end
        if (t > 64'(TIME_MAX))
        begin
            t = 64'(TIME_MAX);
        end
        return t;
    endfunction

    // applies one accepted item to the table; a select yields its expected choice
    task automatic apply_item(logic cmd, path_item_t it);
        choice_t     best;
        logic [63:0] t;
        if (cmd == CMD_WR)
        begin
            tbl_active[it.idx] = it.active;
            tbl_sent[it.idx]   = it.sent;
            tbl_acked[it.idx]  = it.acked;
            tbl_cwnd[it.idx]   = it.cwnd;
            tbl_rtt[it.idx]    = it.rtt;
            tbl_bw[it.idx]     = it.bw;
            tbl_spkts[it.idx]  = it.sent_pkts;
            tbl_lost[it.idx]   = it.lost;
            n_writes++;
        end
        else
        begin
            best = '{path: fallback, found: 1'b0, eta: '0};
            for (int p = 0; p < NPATH; p++)
            begin
                if (tbl_active[p])
                begin
                    t = path_eta(p, it.len);
                    // strictly smaller wins, so the lower index keeps a tie
                    if (!best.found || t < 64'(best.eta))
                    begin
                        best = '{path: IDX_W'(p), found: 1'b1, eta: t[TIME_W-1:0]};
                    end
                end
            end
            if (!best.found)
            begin
                n_fallbacks++;
            end
            pending_choices.push_back(best);
            n_selects++;
        end
    endtask

    // sends one item, with an occasional random gap in front of it
    task automatic send_item(logic cmd, path_item_t it);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        apply_item(cmd, it);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_choices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // fallback register write, only with the block idle
    task automatic write_fallback(logic [IDX_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fallback  = value;
    endtask

    // field values: zero, all ones, small, or fully random
    function automatic logic [63:0] pick_value(int width);
        logic [63:0] mask;
        mask = (width >= 64) ? '1 : ((64'd1 << width) - 1);
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return mask;
            2: return 64'($urandom_range(0, 2000)) & mask;
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    // write item with plausible content: acked near sent most of the time, realistic loss half of the time
    function automatic path_item_t random_path(logic [IDX_W-1:0] idx);
        path_item_t it;
        it        = '0;
        it.idx    = idx;
        it.active = ($urandom_range(0, 2) != 0);
        it.sent   = pick_value(BYTE_W);
        it.acked  = ($urandom_range(0, 2) == 0) ? pick_value(BYTE_W)
                  : it.sent - BYTE_W'($urandom_range(0, 200000));
        it.cwnd   = ($urandom_range(0, 1) == 0) ? pick_value(WIN_W)
                  : WIN_W'($urandom_range(1000, 2000000));
        it.rtt    = ($urandom_range(0, 1) == 0) ? pick_value(RTT_W)
                  : RTT_W'($urandom_range(1000, 300000));
        it.bw     = ($urandom_range(0, 1) == 0) ? pick_value(BW_W)
                  : BW_W'($urandom_range(100000, 200000000));
        if ($urandom_range(0, 1) == 0)
        begin
            it.sent_pkts = pick_value(PKT_W);
            it.lost      = pick_value(PKT_W);
        end
        else
        begin
            it.sent_pkts = $urandom_range(90, 100000);
            it.lost      = (it.sent_pkts * $urandom_range(0, 60)) / 100;
        end
        it.len = LEN_W'(pick_value(LEN_W));
        return it;
    endfunction

    function automatic path_item_t select_of(logic [LEN_W-1:0] len);
        path_item_t it;
        it     = path_item_t'(IN_DW'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom}));
        it.pad = '0;
        it.len = len;
        return it;
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker: every accepted result against the oldest expected choice
    always @(posedge clk)
    begin
        choice_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_choices.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: path %0d found %0b time %0d",
                         $time, m_axis_tdata[2:0], m_axis_tuser, m_axis_tdata[62:3]);
            end
            else
            begin
                want = pending_choices.pop_front();
                n_checked++;
                if (m_axis_tdata[2:0] !== want.path)
                begin
                    errors++;
                    $display("%0t: chosen_path expected %0d actual %0d",
                             $time, want.path, m_axis_tdata[2:0]);
                end
                if (m_axis_tuser !== want.found)
                begin
                    errors++;
                    $display("%0t: found_active expected %0b actual %0b",
                             $time, want.found, m_axis_tuser);
                end
                if (m_axis_tdata[62:3] !== want.eta)
                begin
                    errors++;
                    $display("%0t: eta_us expected %0d actual %0d",
                             $time, want.eta, m_axis_tdata[62:3]);
                end
            end
        end
    end

    // watchdog on cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_earliest_completion_path_select: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // with an empty table every select returns the fallback path
    task automatic test_fallback();
        send_item(CMD_SEL, select_of('0));
        write_fallback(3'd7);
        send_item(CMD_SEL, select_of('1));
        write_fallback(3'd5);
        send_item(CMD_SEL, select_of(16'd1500));
    endtask

    // extremes of the fields and each special case of the estimate
    task automatic test_directed_paths();
        path_item_t it;
        // everything at maximum on path 0
        it = '1;
        it.pad = '0;
        it.idx = 3'd0;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of('1));
        // all unknown on path 7: default rtt and default bandwidth
        it = '0;
        it.idx = 3'd7;
        it.active = 1'b1;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of('0));
        // tiny window over the longest rtt: derived bandwidth rounds to zero
        it = '0;
        it.idx = 3'd3;
        it.active = 1'b1;
        it.cwnd = 32'd1;
        it.rtt = '1;
        it.sent = 48'd500;
        send_item(CMD_WR, it);
        // lossy path: 101 packets, 20 lost, scaled by 100/81
        it = '0;
        it.idx = 3'd1;
        it.active = 1'b1;
        it.rtt = 24'd20000;
        it.bw = 40'd1000000;
        it.cwnd = 32'd65536;
        it.sent = 48'd90000;
        it.acked = 48'd10000;
        it.sent_pkts = 32'd101;
        it.lost = 32'd20;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of(16'd1200));
        // losses above the sent count get no scaling; same table as path 1 otherwise
        it.idx = 3'd2;
        it.lost = 32'd5000;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of(16'd1200));
        // exact tie between paths 4 and 5: the lower index wins
        it = '0;
        it.active = 1'b1;
        it.rtt = 24'd1;
        it.bw = '1;
        it.idx = 3'd5;
        send_item(CMD_WR, it);
        it.idx = 3'd4;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of(16'd64));
        // acked above sent: nothing in flight
        it.idx = 3'd6;
        it.sent = 48'd10;
        it.acked = '1;
        send_item(CMD_WR, it);
        send_item(CMD_SEL, select_of(16'd64));
        // deactivate every path again, back to fallback
        for (int p = 0; p < NPATH; p++)
        begin
            it = '0;
            it.idx = IDX_W'(p);
            send_item(CMD_WR, it);
        end
        send_item(CMD_SEL, select_of(16'd7));
    endtask

    // random writes and selects over several fallback settings
    task automatic test_random_traffic();
        int quiet_from;
        quiet_from = RAND_ITEMS * 85 / 100;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 4 || n == RAND_ITEMS / 2)
            begin
                write_fallback(IDX_W'($urandom_range(0, 7)));
            end
            if (n == RAND_ITEMS / 3)
            begin
                // receiver holds off while selects keep coming: the block fills up
                long_hold_req = 1'b1;
            end
            if (n == RAND_ITEMS * 2 / 3)
            begin
                // sender pause until every result is back
                wait_drained();
            end
            if (n == quiet_from)
            begin
                gaps_on = 1'b0;
            end
            if ($urandom_range(0, 99) < 45)
            begin
                send_item(CMD_SEL, select_of(LEN_W'(pick_value(LEN_W))));
            end
            else
            begin
                send_item(CMD_WR, random_path(IDX_W'($urandom_range(0, 7))));
            end
        end
        stop_sending();
    endtask

    initial
    begin
        errors = 0;
        n_writes = 0;
        n_selects = 0;
        n_fallbacks = 0;
        n_checked = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        long_hold_req = 1'b0;
        fallback = '0;
        for (int p = 0; p < NPATH; p++)
        begin
            tbl_active[p] = 1'b0;
            tbl_sent[p]   = '0;
            tbl_acked[p]  = '0;
            tbl_cwnd[p]   = '0;
            tbl_rtt[p]    = '0;
            tbl_bw[p]     = '0;
            tbl_spkts[p]  = '0;
            tbl_lost[p]   = '0;
        end
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fallback();
        test_directed_paths();
        write_fallback(3'd0);
        test_random_traffic();
        write_fallback(3'd6);
        send_item(CMD_SEL, select_of(16'd100));
        stop_sending();

        wait_drained();
        repeat (40) @(posedge clk);
        $display("covered %0d writes and %0d selects, %0d of them on fallback",
                 n_writes, n_selects, n_fallbacks);
        $display("%0d results checked", n_checked);
        if (errors == 0)
        begin
            $display("tb_earliest_completion_path_select: PASS");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("tb_earliest_completion_path_select: FAIL");
        end
        $finish;
    end

endmodule

### earliest_completion_path_select.f
hdl/ecps_pkg.sv
hdl/ecps_div.sv
hdl/ecps_datapath.sv
hdl/ecps_ctrl.sv
hdl/earliest_completion_path_select.sv
test/tb_earliest_completion_path_select.sv
